// ===== rtl/core/canrx_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN reassembly package
// Shared constants, the CRC-16/Modbus byte update and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package canrx_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam int          MSG_LIMIT    = 128;
   localparam int          SINGLE_LIMIT = 8;
   localparam int          SEG_DATA     = 6;
   localparam int          MAX_SEGMENTS = 16;
   localparam int          SEGIDX_W     = $clog2(MAX_SEGMENTS);
   localparam int          IDX_W        = 8;
   localparam int          POS_W        = 9;
   localparam logic [6:0]  AUX_RESET    = 7'd127;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic seg_wr;
      logic scan_start;
      logic fetch;
      logic scan;
      logic emit_start;
      logic fill;
      logic push;
   } canrx_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clr_last;
      logic is_long;
      logic seg_ok;
      logic seg_final;
      logic seg_wr_last;
      logic scan_abort;
      logic scan_done;
      logic msg_ok;
      logic fill_done;
      logic chunk_last;
      logic out_free;
   } canrx_sts_type;

   // One byte of CRC-16/Modbus, least significant bit first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_val,
                                              input logic [7:0]  data_byte);
      logic [15:0] c;
      c = crc_val ^ {8'h00, data_byte};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/canrx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module canrx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/canrx_dp.sv =====
// ----------------------------------------------------------------------------
// CAN reassembly datapath
// Frame capture, segment buffer, byte-serial CRC scan, chunk assembly and the
// result register.
// ----------------------------------------------------------------------------
module canrx_dp import canrx_pkg::*; #(
   parameter int BUF_BYTES = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  canrx_cmd_type cmd,
   output canrx_sts_type sts,
   input  logic          req_is_long,
   input  logic [63:0]   req_frame_bytes,
   input  logic          csr_wr_en,
   input  logic [6:0]    csr_wr_data,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [6:0]    rsp_reg_addr,
   output logic          rsp_is_write,
   output logic [6:0]    rsp_payload_len,
   output logic [3:0]    rsp_chunk_index,
   output logic [63:0]   rsp_chunk_data,
   output logic [3:0]    rsp_chunk_bytes,
   output logic          rsp_last
);

   localparam int ADDR_W  = $clog2(BUF_BYTES);
   localparam int MSG_MAX = (BUF_BYTES < MSG_LIMIT) ? BUF_BYTES : MSG_LIMIT;

   // Control registers.
   logic [6:0]        aux_ff, aux_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              cur_valid_ff, cur_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [63:0]      frame_ff, frame_in;
   logic             long_ff, long_in;
   logic [2:0]       wi_ff, wi_in;
   logic [IDX_W-1:0] fetch_ff, fetch_in;
   logic [IDX_W-1:0] cur_idx_ff, cur_idx_in;
   logic [7:0]       frame_byte_ff, frame_byte_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       reg_byte_ff, reg_byte_in;
   logic [7:0]       plen_ff, plen_in;
   logic [7:0]       rx_hi_ff, rx_hi_in;
   logic [7:0]       rx_lo_ff, rx_lo_in;
   logic [6:0]       rem_ff, rem_in;
   logic [3:0]       nf_ff, nf_in;
   logic [3:0]       k_ff, k_in;
   logic [63:0]      chunk_ff, chunk_in;
   logic [6:0]       o_reg_ff, o_reg_in;
   logic             o_wr_ff, o_wr_in;
   logic [6:0]       o_len_ff, o_len_in;
   logic [3:0]       o_idx_ff, o_idx_in;
   logic [63:0]      o_data_ff, o_data_in;
   logic [3:0]       o_cnt_ff, o_cnt_in;
   logic             o_last_ff, o_last_in;

   // Memory port.
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   // Combinational helpers.
   logic [7:0]       seg_total;
   logic [7:0]       seg_idx;
   logic [POS_W-1:0] seg_pos;
   logic [7:0]       seg_byte;
   logic             fetch_go;
   logic [7:0]       cur_byte;
   logic             len_bad;
   logic [8:0]       plen_ext;
   logic [8:0]       idx_ext;
   logic             crc_take;
   logic [3:0]       chunk_cnt;
   logic             fill_more;
   logic [2:0]       lane;
   logic             out_free;

   canrx_ram #(
      .WIDTH (8),
      .DEPTH (BUF_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      seg_total = frame_ff[7:0];
      seg_idx   = frame_ff[63:56];
      seg_pos   = POS_W'(seg_idx[SEGIDX_W-1:0]) * POS_W'(SEG_DATA) + POS_W'(wi_ff);
      seg_byte  = frame_ff[{3'(wi_ff + 3'd1), 3'b000} +: 8];

      ram_we    = cmd.clear | (cmd.seg_wr & (seg_pos < POS_W'(BUF_BYTES)));
      ram_waddr = cmd.clear ? clr_ff : seg_pos[ADDR_W-1:0];
      ram_wdata = cmd.clear ? 8'h00 : seg_byte;
      ram_raddr = fetch_ff[ADDR_W-1:0];

      cur_byte  = long_ff ? ram_rdata : frame_byte_ff;
      plen_ext  = {1'b0, plen_ff};
      idx_ext   = {1'b0, cur_idx_ff};
      len_bad   = long_ff ? ({1'b0, cur_byte} + 9'd4 > 9'(MSG_MAX))
                          : ({1'b0, cur_byte} + 9'd4 > 9'(SINGLE_LIMIT));
      crc_take  = (cur_idx_ff < IDX_W'(2)) || (idx_ext < plen_ext + 9'd2);

      chunk_cnt = (rem_ff > 7'd8) ? 4'd8 : rem_ff[3:0];
      fill_more = nf_ff < chunk_cnt;
      fetch_go  = cmd.fetch | (cmd.fill & fill_more);
      lane      = cur_idx_ff[2:0] - 3'd2;
      out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      sts.clr_last    = clr_ff == ADDR_W'(BUF_BYTES - 1);
      sts.is_long     = long_ff;
      sts.seg_ok      = (seg_total <= 8'(MAX_SEGMENTS)) && (seg_idx < seg_total);
      sts.seg_final   = ({1'b0, seg_idx} + 9'd1) == {1'b0, seg_total};
      sts.seg_wr_last = wi_ff == 3'(SEG_DATA - 1);
      sts.scan_abort  = cur_valid_ff && (cur_idx_ff == IDX_W'(1)) && len_bad;
      sts.scan_done   = cur_valid_ff && (cur_idx_ff >= IDX_W'(2))
                        && (idx_ext == plen_ext + 9'd3);
      sts.msg_ok      = (crc_ff == {rx_hi_ff, rx_lo_ff})
                        && !(long_ff && (reg_byte_ff[6:0] == aux_ff));
      sts.fill_done   = !fill_more && !cur_valid_ff;
      sts.chunk_last  = rem_ff <= 7'd8;
      sts.out_free    = out_free;
   end

   // Next-state logic.
   always_comb begin
      aux_in        = csr_wr_en ? csr_wr_data : aux_ff;
      clr_in        = cmd.clear ? clr_ff + ADDR_W'(1) : clr_ff;
      cur_valid_in  = fetch_go;
      frame_in      = cmd.capture ? req_frame_bytes : frame_ff;
      long_in       = cmd.capture ? req_is_long : long_ff;
      wi_in         = cmd.capture ? 3'd0 : (cmd.seg_wr ? wi_ff + 3'd1 : wi_ff);
      fetch_in      = fetch_ff;
      cur_idx_in    = cur_idx_ff;
      frame_byte_in = frame_byte_ff;
      crc_in        = crc_ff;
      reg_byte_in   = reg_byte_ff;
      plen_in       = plen_ff;
      rx_hi_in      = rx_hi_ff;
      rx_lo_in      = rx_lo_ff;
      rem_in        = rem_ff;
      nf_in         = nf_ff;
      k_in          = k_ff;
      chunk_in      = chunk_ff;

      if (fetch_go) begin
         fetch_in      = fetch_ff + IDX_W'(1);
         cur_idx_in    = fetch_ff;
         frame_byte_in = frame_ff[{fetch_ff[2:0], 3'b000} +: 8];
      end

      if (cmd.scan_start) begin
         fetch_in = '0;
         crc_in   = CRC_INIT;
      end

      if (cmd.scan && cur_valid_ff) begin
         if (crc_take) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
         if (cur_idx_ff == IDX_W'(0)) begin
            reg_byte_in = cur_byte;
         end
         if (cur_idx_ff == IDX_W'(1)) begin
            plen_in = cur_byte;
         end
         if ((cur_idx_ff >= IDX_W'(2)) && (idx_ext == plen_ext + 9'd2)) begin
            rx_hi_in = cur_byte;
         end
         if ((cur_idx_ff >= IDX_W'(2)) && (idx_ext == plen_ext + 9'd3)) begin
            rx_lo_in = cur_byte;
         end
      end

      if (cmd.emit_start) begin
         fetch_in = IDX_W'(2);
         rem_in   = plen_ff[6:0];
         nf_in    = 4'd0;
         k_in     = 4'd0;
         chunk_in = '0;
      end

      if (cmd.fill) begin
         if (fill_more) begin
            nf_in = nf_ff + 4'd1;
         end
         if (cur_valid_ff) begin
            chunk_in[{lane, 3'b000} +: 8] = cur_byte;
         end
      end

      if (cmd.push) begin
         rem_in   = rem_ff - 7'(chunk_cnt);
         nf_in    = 4'd0;
         k_in     = k_ff + 4'd1;
         chunk_in = '0;
      end
   end

   // Result register: loads a finished chunk while the previous one leaves.
   always_comb begin
      rsp_valid_in = cmd.push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      o_reg_in     = o_reg_ff;
      o_wr_in      = o_wr_ff;
      o_len_in     = o_len_ff;
      o_idx_in     = o_idx_ff;
      o_data_in    = o_data_ff;
      o_cnt_in     = o_cnt_ff;
      o_last_in    = o_last_ff;
      if (cmd.push) begin
         o_reg_in  = reg_byte_ff[6:0];
         o_wr_in   = reg_byte_ff[7];
         o_len_in  = plen_ff[6:0];
         o_idx_in  = k_ff;
         o_data_in = chunk_ff;
         o_cnt_in  = chunk_cnt;
         o_last_in = rem_ff <= 7'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aux_ff       <= AUX_RESET;
         clr_ff       <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         aux_ff       <= aux_in;
         clr_ff       <= clr_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff      <= frame_in;
      long_ff       <= long_in;
      wi_ff         <= wi_in;
      fetch_ff      <= fetch_in;
      cur_idx_ff    <= cur_idx_in;
      frame_byte_ff <= frame_byte_in;
      crc_ff        <= crc_in;
      reg_byte_ff   <= reg_byte_in;
      plen_ff       <= plen_in;
      rx_hi_ff      <= rx_hi_in;
      rx_lo_ff      <= rx_lo_in;
      rem_ff        <= rem_in;
      nf_ff         <= nf_in;
      k_ff          <= k_in;
      chunk_ff      <= chunk_in;
      o_reg_ff      <= o_reg_in;
      o_wr_ff       <= o_wr_in;
      o_len_ff      <= o_len_in;
      o_idx_ff      <= o_idx_in;
      o_data_ff     <= o_data_in;
      o_cnt_ff      <= o_cnt_in;
      o_last_ff     <= o_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_addr    = o_reg_ff;
   assign rsp_is_write    = o_wr_ff;
   assign rsp_payload_len = o_len_ff;
   assign rsp_chunk_index = o_idx_ff;
   assign rsp_chunk_data  = o_data_ff;
   assign rsp_chunk_bytes = o_cnt_ff;
   assign rsp_last        = o_last_ff;

endmodule

// ===== rtl/core/canrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// CAN reassembly controller
// Sequences buffer clearing, segment writes, the CRC scan and chunk output.
// ----------------------------------------------------------------------------
module canrx_ctrl import canrx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  canrx_sts_type sts,
   output canrx_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_DECODE = 8'b0000_0100,
      ST_WRITE  = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_VERIFY = 8'b0010_0000,
      ST_FILL   = 8'b0100_0000,
      ST_PUSH   = 8'b1000_0000
   } canrx_state_type;

   canrx_state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.is_long) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else if (sts.seg_ok) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            cmd.seg_wr = 1'b1;
            if (sts.seg_wr_last) begin
               if (sts.seg_final) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            cmd.fetch = 1'b1;
            cmd.scan  = 1'b1;
            if (sts.scan_abort) begin
               state_in = ST_IDLE;
            end else if (sts.scan_done) begin
               state_in = ST_VERIFY;
            end
         end
         ST_VERIFY: begin
            if (sts.msg_ok) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_FILL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (sts.fill_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = sts.chunk_last ? ST_IDLE : ST_FILL;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/can_segment_reassembly_crc16_check_top.sv =====
// ----------------------------------------------------------------------------
// CAN segment reassembly with CRC-16/Modbus check
// Takes 8-byte CAN frames, reassembles segmented messages, checks them and
// delivers valid payloads in chunks of up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one CAN frame per beat: req_is_long marks a segment
// of a long message, req_frame_bytes holds the eight frame bytes with byte 0
// in the low bits. The rsp channel delivers one payload chunk per beat, with
// the register number, the write flag, the payload length, the chunk number,
// up to eight payload bytes and rsp_last on the final chunk of a message.
// Messages that fail the length or CRC check produce no beats at all, and so
// do valid long messages addressed to the aux register set through csr_wr_en
// and csr_wr_data (reset value 127). Write that register only while idle.
// After reset the block zeroes its segment buffer, one byte per cycle, and
// req_ready stays low until it is done. Frames are handled one at a time.
// A message that fails its check leaves the block at the end of its scan.
// The buffer has a byte-wide read port: the CRC scan and the chunk fill walk
// the buffer one byte per cycle. A finished chunk waits in an output register,
// so a stalled receiver holds the block only when another chunk is ready while
// the previous one still waits; the last chunk of a message never blocks req.
// ----------------------------------------------------------------------------
module can_segment_reassembly_crc16_check_top import canrx_pkg::*; #(
   parameter int BUF_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_long,
   input  logic [63:0] req_frame_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_reg_addr,
   output logic        rsp_is_write,
   output logic [6:0]  rsp_payload_len,
   output logic [3:0]  rsp_chunk_index,
   output logic [63:0] rsp_chunk_data,
   output logic [3:0]  rsp_chunk_bytes,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   // The controller holds only its state and issues commands; all other storage lives in the datapath.
   canrx_cmd_type cmd;
   canrx_sts_type sts;

   canrx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   canrx_dp #(
      .BUF_BYTES (BUF_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_is_long     (req_is_long),
      .req_frame_bytes (req_frame_bytes),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_reg_addr    (rsp_reg_addr),
      .rsp_is_write    (rsp_is_write),
      .rsp_payload_len (rsp_payload_len),
      .rsp_chunk_index (rsp_chunk_index),
      .rsp_chunk_data  (rsp_chunk_data),
      .rsp_chunk_bytes (rsp_chunk_bytes),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/core/canrx_checker.sv =====
// ----------------------------------------------------------------------------
// CAN reassembly port checker
// Watches the top-level ports and flags chunks that break the output format.
// ----------------------------------------------------------------------------
module canrx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_payload_len,
   input logic [3:0]  rsp_chunk_index,
   input logic [63:0] rsp_chunk_data,
   input logic [3:0]  rsp_chunk_bytes,
   input logic        rsp_last
);

   // A stalled beat keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_data)
                                  && $stable(rsp_chunk_index) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // Only the final chunk of a message may be partly filled.
   a_full_chunks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunk_bytes <= 4'd8) && (rsp_last || rsp_chunk_bytes == 4'd8))
      else $error("chunk byte count out of place");

   // The final chunk closes the payload exactly.
   a_last_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |->
         rsp_payload_len == 7'({rsp_chunk_index, 3'b000}) + 7'(rsp_chunk_bytes))
      else $error("last chunk does not match the payload length");

   // Bytes past the valid count read as zero.
   a_zero_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_bytes < 4'd8 |->
         (rsp_chunk_data >> {rsp_chunk_bytes, 3'b000}) == 64'd0)
      else $error("chunk carries stray bytes");

   // Right after reset the buffer clear is running and nothing is offered.
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("block active right after reset");

endmodule

bind can_segment_reassembly_crc16_check_top canrx_checker u_checker (.*);
